// File: hw/rtl/rlspe_pkg.sv
// ----------------------------------------------------------------------------
// rlspe_pkg
// Shared types and constants of the RGB LED strip bitstream encoder.
// ----------------------------------------------------------------------------
package rlspe_pkg;

  // Color layout: green in 23:16, red in 15:8, blue in 7:0
  localparam int BITS_PER_COLOR = 8;
  localparam int BITS_PER_LED   = 3 * BITS_PER_COLOR;
  localparam int COLOR_W        = BITS_PER_LED;
  localparam int BITPOS_W       = 5;

  // Field widths
  localparam int DUTY_W          = 16;
  localparam int RESET_SLOTS_W   = 12;
  localparam int LED_COUNT_W     = 9;
  localparam int LED_IDX_FIELD_W = 10;
  localparam int FUNC_W          = 2;
  localparam int PHASE_W         = 2;

  // Stream and register port widths
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 24;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  // Input word kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_START = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  // Frame phase codes
  localparam logic [PHASE_W-1:0] PHASE_IDLE  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_DATA  = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_RESET = 2'd2;

  // Register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_DUTY_ONE    = 2'd0;
  localparam logic [1:0] REG_DUTY_ZERO   = 2'd1;
  localparam logic [1:0] REG_RESET_SLOTS = 2'd2;
  localparam logic [1:0] REG_LED_COUNT   = 2'd3;

  // Per-word info handed from the sequencer to the result stage
  typedef struct packed {
    logic                use_color;
    logic                active;
    logic                write_error;
    logic [PHASE_W-1:0]  phase;
    logic [BITPOS_W-1:0] bit_pos;
  } s1_info_t;

endpackage

// File: hw/rtl/rlspe_ram.sv
// ----------------------------------------------------------------------------
// rlspe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rlspe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/rlspe_ctrl.sv
// ----------------------------------------------------------------------------
// rlspe_ctrl
// Frame sequencer: decodes input words, steps the LED, bit and reset counters,
// drives the color RAM and clears it after reset.
// ----------------------------------------------------------------------------
module rlspe_ctrl #(
  parameter int MAX_LEDS = 256,
  parameter int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Input words
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  rlspe_pkg::func_e                       func_i,
  input  logic [rlspe_pkg::LED_IDX_FIELD_W-1:0]  led_index_i,
  input  logic [rlspe_pkg::BITS_PER_COLOR-1:0]   red_i,
  input  logic [rlspe_pkg::BITS_PER_COLOR-1:0]   green_i,
  input  logic [rlspe_pkg::BITS_PER_COLOR-1:0]   blue_i,
  // Configuration
  input  logic [rlspe_pkg::RESET_SLOTS_W-1:0]    reset_slots_i,
  input  logic [rlspe_pkg::LED_COUNT_W-1:0]      led_count_i,
  // Result stage
  input  logic                                   s1_ready_i,
  output logic                                   s1_push_o,
  output rlspe_pkg::s1_info_t                    s1_info_o,
  // Color RAM
  output logic                                   ram_we_o,
  output logic [IDX_W-1:0]                       ram_waddr_o,
  output logic [rlspe_pkg::COLOR_W-1:0]          ram_wdata_o,
  output logic                                   ram_re_o,
  output logic [IDX_W-1:0]                       ram_raddr_o
);

  import rlspe_pkg::*;

  localparam int EFF_W = $clog2(MAX_LEDS + 1);
  localparam int CMP_W = ((EFF_W > LED_IDX_FIELD_W) ? EFF_W : LED_IDX_FIELD_W) + 1;
  localparam int RST_CMP_W = RESET_SLOTS_W + 1;

  logic [PHASE_W-1:0]       phase_q, phase_d;
  logic [IDX_W-1:0]         led_q, led_d;
  logic [BITPOS_W-1:0]      bit_q, bit_d;
  logic [RESET_SLOTS_W-1:0] rst_cnt_q, rst_cnt_d;
  logic                     clr_busy_q, clr_busy_d;
  logic [IDX_W-1:0]         clr_addr_q, clr_addr_d;

  logic                     accept;
  logic [CMP_W-1:0]         eff_count;
  logic [PHASE_W-1:0]       reset_entry_phase;
  logic                     last_led;
  logic                     last_slot;

  assign in_ready_o = !clr_busy_q && s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign s1_push_o  = accept;

  // Effective LED count, capped at the store depth
  assign eff_count = (CMP_W'(led_count_i) > CMP_W'(MAX_LEDS)) ? CMP_W'(MAX_LEDS)
                                                             : CMP_W'(led_count_i);

  assign reset_entry_phase = (reset_slots_i == '0) ? PHASE_IDLE : PHASE_RESET;
  assign last_led  = (CMP_W'(led_q) + CMP_W'(1)) >= eff_count;
  assign last_slot = (RST_CMP_W'(rst_cnt_q) + RST_CMP_W'(1)) >= RST_CMP_W'(reset_slots_i);

  // Decode the word and step the frame counters
  always_comb begin
    phase_d     = phase_q;
    led_d       = led_q;
    bit_d       = bit_q;
    rst_cnt_d   = rst_cnt_q;
    clr_busy_d  = clr_busy_q;
    clr_addr_d  = clr_addr_q;
    s1_info_o   = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = led_index_i[IDX_W-1:0];
    ram_wdata_o = {green_i, red_i, blue_i};
    ram_re_o    = 1'b0;
    ram_raddr_o = led_q;

    // Clear the color store after reset, one entry a cycle
    if (clr_busy_q) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = clr_addr_q;
      ram_wdata_o = '0;
      if (clr_addr_q == IDX_W'(MAX_LEDS - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + IDX_W'(1);
      end
    end

    if (accept) begin
      case (func_i)
        FUNC_WRITE: begin
          if (CMP_W'(led_index_i) >= eff_count) begin
            s1_info_o.write_error = 1'b1;
          end else begin
            ram_we_o = 1'b1;
          end
        end
        FUNC_START: begin
          if (phase_q == PHASE_IDLE) begin
            led_d     = '0;
            bit_d     = '0;
            rst_cnt_d = '0;
            phase_d   = (eff_count == '0) ? reset_entry_phase : PHASE_DATA;
          end
        end
        FUNC_TICK: begin
          case (phase_q)
            PHASE_DATA: begin
              ram_re_o            = 1'b1;
              s1_info_o.use_color = 1'b1;
              s1_info_o.active    = 1'b1;
              s1_info_o.bit_pos   = BITPOS_W'(BITS_PER_LED - 1) - bit_q;
              if (bit_q >= BITPOS_W'(BITS_PER_LED - 1)) begin
                bit_d = '0;
                if (last_led) begin
                  led_d     = '0;
                  rst_cnt_d = '0;
                  phase_d   = reset_entry_phase;
                end else begin
                  led_d = led_q + IDX_W'(1);
                end
              end else begin
                bit_d = bit_q + BITPOS_W'(1);
              end
            end
            PHASE_RESET: begin
              s1_info_o.active = 1'b1;
              if (last_slot) begin
                rst_cnt_d = '0;
                phase_d   = PHASE_IDLE;
              end else begin
                rst_cnt_d = rst_cnt_q + RESET_SLOTS_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    s1_info_o.phase = phase_d;
  end

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PHASE_IDLE;
      led_q      <= '0;
      bit_q      <= '0;
      rst_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      phase_q    <= phase_d;
      led_q      <= led_d;
      bit_q      <= bit_d;
      rst_cnt_q  <= rst_cnt_d;
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

endmodule

// File: hw/rtl/rlspe_out.sv
// ----------------------------------------------------------------------------
// rlspe_out
// Result stage: holds each word's info while the color RAM read lands, picks
// the bit and duty, and holds the finished word in the output register.
// ----------------------------------------------------------------------------
module rlspe_out (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // From the sequencer
  input  logic                                 s1_push_i,
  input  rlspe_pkg::s1_info_t                  s1_info_i,
  output logic                                 s1_ready_o,
  // Color RAM read data
  input  logic [rlspe_pkg::COLOR_W-1:0]        rdata_i,
  // Configuration
  input  logic [rlspe_pkg::DUTY_W-1:0]         duty_one_i,
  input  logic [rlspe_pkg::DUTY_W-1:0]         duty_zero_i,
  // Result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [rlspe_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

  import rlspe_pkg::*;

  logic                s1_valid_q;
  s1_info_t            s1_q;
  logic                out_valid_q;
  logic [DUTY_W-1:0]   duty_q, duty_d;
  logic                active_q;
  logic                err_q;
  logic [PHASE_W-1:0]  phase_q;
  logic                out_take;

  assign out_take   = !out_valid_q || m_axis_tready;
  assign s1_ready_o = !s1_valid_q || out_take;

  // Pick the duty from the addressed color bit
  always_comb begin
    duty_d = '0;
    if (s1_q.use_color) begin
      duty_d = rdata_i[s1_q.bit_pos] ? duty_one_i : duty_zero_i;
    end
  end

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready_o) begin
        s1_valid_q <= s1_push_i;
      end
      if (out_take) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Load payloads
  always_ff @(posedge clk_i) begin
    if (s1_ready_o && s1_push_i) begin
      s1_q <= s1_info_i;
    end
    if (out_take && s1_valid_q) begin
      duty_q   <= duty_d;
      active_q <= s1_q.active;
      err_q    <= s1_q.write_error;
      phase_q  <= s1_q.phase;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, phase_q, err_q, active_q, duty_q};

endmodule

// File: hw/rtl/rgb_led_strip_pwm_encoder.sv
// ----------------------------------------------------------------------------
// rgb_led_strip_pwm_encoder
// Bitstream encoder for a WS2812-type LED strip, one PWM compare value a tick.
// ----------------------------------------------------------------------------
// Accepts one word per clock while s_axis_tready is high and returns one
// result word per input word. Each word passes the registered color RAM read
// and then the output register; s_axis_tready falls when both hold a word
// and the result is stalled. Color writes, start requests and period ticks
// all run at that rate. After reset the color RAM is cleared to black, one
// entry a cycle, so s_axis_tready stays low until the clear ends; registers
// can be written meanwhile. Registers are at byte addresses 0x0 duty_one,
// 0x4 duty_zero, 0x8 reset_slots, 0xC led_count. The user must change them
// only while no frame word is in flight; the block leaves this to the user.
module rgb_led_strip_pwm_encoder #(
  parameter int MAX_LEDS = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input words
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [9:0] led_index, [17:10] red, [25:18] green, [33:26] blue, [39:34] zero
  input  logic [rlspe_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] func
  input  logic [rlspe_pkg::FUNC_W-1:0]       s_axis_tuser,
  // Result words
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [15:0] duty, [16] line_active, [17] write_error, [19:18] phase, [23:20] zero
  output logic [rlspe_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // Register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rlspe_pkg::APB_AW-1:0]       paddr,
  input  logic [rlspe_pkg::APB_DW-1:0]       pwdata,
  output logic [rlspe_pkg::APB_DW-1:0]       prdata,
  output logic                               pready
);

  import rlspe_pkg::*;

  localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  logic [DUTY_W-1:0]        duty_one_q;
  logic [DUTY_W-1:0]        duty_zero_q;
  logic [RESET_SLOTS_W-1:0] reset_slots_q;
  logic [LED_COUNT_W-1:0]   led_count_q;
  logic                     reg_wr;
  logic [1:0]               reg_idx;

  logic                     s1_ready;
  logic                     s1_push;
  s1_info_t                 s1_info;
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [COLOR_W-1:0]       ram_wdata;
  logic                     ram_re;
  logic [IDX_W-1:0]         ram_raddr;
  logic [COLOR_W-1:0]       ram_rdata;

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_one_q    <= '0;
      duty_zero_q   <= '0;
      reset_slots_q <= RESET_SLOTS_W'(64);
      led_count_q   <= LED_COUNT_W'(256);
    end else if (reg_wr) begin
      case (reg_idx)
        REG_DUTY_ONE:    duty_one_q    <= pwdata[DUTY_W-1:0];
        REG_DUTY_ZERO:   duty_zero_q   <= pwdata[DUTY_W-1:0];
        REG_RESET_SLOTS: reset_slots_q <= pwdata[RESET_SLOTS_W-1:0];
        REG_LED_COUNT:   led_count_q   <= pwdata[LED_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (reg_idx)
      REG_DUTY_ONE:    prdata = APB_DW'(duty_one_q);
      REG_DUTY_ZERO:   prdata = APB_DW'(duty_zero_q);
      REG_RESET_SLOTS: prdata = APB_DW'(reset_slots_q);
      REG_LED_COUNT:   prdata = APB_DW'(led_count_q);
      default:         prdata = '0;
    endcase
  end

  rlspe_ctrl #(
    .MAX_LEDS (MAX_LEDS),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .func_i        (func_e'(s_axis_tuser)),
    .led_index_i   (s_axis_tdata[9:0]),
    .red_i         (s_axis_tdata[17:10]),
    .green_i       (s_axis_tdata[25:18]),
    .blue_i        (s_axis_tdata[33:26]),
    .reset_slots_i (reset_slots_q),
    .led_count_i   (led_count_q),
    .s1_ready_i    (s1_ready),
    .s1_push_o     (s1_push),
    .s1_info_o     (s1_info),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr)
  );

  rlspe_ram #(
    .WIDTH  (COLOR_W),
    .DEPTH  (MAX_LEDS),
    .ADDR_W (IDX_W)
  ) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rlspe_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s1_push_i     (s1_push),
    .s1_info_i     (s1_info),
    .s1_ready_o    (s1_ready),
    .rdata_i       (ram_rdata),
    .duty_one_i    (duty_one_q),
    .duty_zero_i   (duty_zero_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: hw/rtl/rlspe_checker.sv
// ----------------------------------------------------------------------------
// rlspe_checker
// Port-level checks of the LED strip encoder, bound to the top level.
// ----------------------------------------------------------------------------
module rlspe_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [rlspe_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  import rlspe_pkg::*;

  // A stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Idle line carries zero duty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[15:0] == '0)
    else $error("nonzero duty on an inactive period");

  // A write error never comes with an active line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17] |-> !m_axis_tdata[16])
    else $error("write error flagged on an active period");

  // A result appears on an empty output only for a word taken earlier, after it passes the info and output registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result word without a matching input word");

endmodule

bind rgb_led_strip_pwm_encoder rlspe_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
